// ===== rtl/register_alu_with_branch_timing_defines.svh =====
// Assertion macros shared by the checker.
`ifndef REGISTER_ALU_WITH_BRANCH_TIMING_DEFINES_SVH
`define REGISTER_ALU_WITH_BRANCH_TIMING_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define RABT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked outside reset.
`define RABT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/rabt_pkg.sv =====
`default_nettype none
package rabt_pkg;
    localparam int unsigned DataW = 32;
    localparam int unsigned LatW  = 8;
    localparam int unsigned NumCfg = 6;
    localparam int unsigned CfgIdxW = 3;

    typedef enum logic [2:0] {
        OP_ADD  = 3'd0,
        OP_SUB  = 3'd1,
        OP_MUL  = 3'd2,
        OP_DIV  = 3'd3,
        OP_LOAD = 3'd4,
        OP_JUMP = 3'd5
    } t_op;

    localparam logic [CfgIdxW-1:0] CFG_LAT_ADD  = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_LAT_SUB  = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_LAT_MUL  = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_LAT_DIV  = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_LAT_LOAD = 3'd4;
    localparam logic [CfgIdxW-1:0] CFG_LAT_JUMP = 3'd5;

    typedef struct packed {
        logic [2:0]  mode;
        logic [31:0] dest_or_compare;
        logic [31:0] src_a_or_imm;
        logic [31:0] src_b_or_offset;
    } t_in_item;

    typedef struct packed {
        logic [31:0]        issue_cycle;
        logic [31:0]        exec_cycle;
        logic [31:0]        writeback_cycle;
        logic signed [31:0] pc_step;
        logic               wrote_register;
        logic signed [31:0] written_value;
    } t_out_item;
endpackage
`default_nettype wire

// ===== rtl/rabt_front.sv =====
`default_nettype none
// Front end: a two-entry transaction queue that decouples input from execution.
module rabt_front
    import rabt_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_push,
    output logic          o_full,
    input  wire t_in_item i_item,
    output logic          o_valid,
    input  wire logic     i_take,
    output t_in_item      o_item
);
    t_in_item   r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_push, w_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_q[r_rp];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_take && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= i_item;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end
endmodule
`default_nettype wire

// ===== rtl/rabt_div.sv =====
`default_nettype none
// Iterative unsigned restoring divider, one quotient bit per cycle.
module rabt_div
    import rabt_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [DataW-1:0]  i_num,
    input  wire logic [DataW-1:0]  i_den,
    output logic                   o_done,
    output logic [DataW-1:0]       o_quot
);
    logic [DataW-1:0] r_quot, r_den;
    logic [DataW:0]   r_rem;
    logic [5:0]       r_cnt;
    logic             r_busy;
    logic [DataW:0]   w_shift, w_diff;

    assign w_shift = {r_rem[DataW-1:0], r_quot[DataW-1]};
    assign w_diff  = w_shift - {1'b0, r_den};
    assign o_quot  = r_quot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'(DataW);
                r_quot <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
            end else if (r_busy) begin
                if (!w_diff[DataW]) begin
                    r_rem  <= w_diff;
                    r_quot <= {r_quot[DataW-2:0], 1'b1};
                end else begin
                    r_rem  <= w_shift;
                    r_quot <= {r_quot[DataW-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
endmodule
`default_nettype wire

// ===== rtl/rabt_back.sv =====
`default_nettype none
// Back end: register file, execution sequencer, timing stamps, output register.
module rabt_back
    import rabt_pkg::*;
#(
    parameter int unsigned NUM_REGS = 32
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_take,
    input  wire t_in_item          i_item,
    input  wire logic [LatW-1:0]   i_lat [NumCfg],
    output logic                   o_empty,
    input  wire logic              i_pop,
    output t_out_item              o_item
);
    localparam int unsigned IdxW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

    typedef enum logic [2:0] {
        S_IDLE, S_CLEAR, S_IDX, S_READ, S_EXEC, S_DIVW, S_DONE
    } t_state;

    t_state            r_state;
    logic [DataW-1:0]  r_rf [NUM_REGS];
    logic [IdxW:0]     r_clr;
    t_in_item          r_ins;
    logic [IdxW-1:0]   r_ia, r_ib, r_id;
    logic [1:0]        r_step;
    logic [DataW-1:0]  r_a, r_b, r_val;
    logic [DataW-1:0]  r_cycle;
    logic              r_out_v;
    t_out_item         r_out;
    logic              w_div_start, w_div_done;
    logic [DataW-1:0]  w_quot, w_ma, w_mb;
    logic [DataW-1:0]  w_lat;

    // Folds eight more bits into a running remainder modulo NUM_REGS, most
    // significant bit first, with one compare and subtract per bit.
    function automatic logic [IdxW-1:0] reduce_chunk(input logic [IdxW-1:0] rem,
                                                     input logic [7:0] chunk);
        logic [IdxW:0]   t;
        logic [IdxW-1:0] acc;
        acc = rem;
        for (int k = 7; k >= 0; k--) begin
            t = {acc, chunk[k]};
            if (t >= (IdxW+1)'(NUM_REGS)) t = t - (IdxW+1)'(NUM_REGS);
            acc = t[IdxW-1:0];
        end
        return acc;
    endfunction

    // Byte k of a word, counted from the most significant end.
    function automatic logic [7:0] pick_chunk(input logic [DataW-1:0] x, input logic [1:0] k);
        return 8'(x >> {~k, 3'b000});
    endfunction

    assign w_ma = r_a[DataW-1] ? (DataW'(0) - r_a) : r_a;
    assign w_mb = r_b[DataW-1] ? (DataW'(0) - r_b) : r_b;
    assign w_div_start = (r_state == S_EXEC) && (r_ins.mode == OP_DIV) && (r_b != '0);
    assign o_take  = (r_state == S_IDLE) && i_valid && !r_out_v;
    assign o_empty = !r_out_v;
    assign o_item  = r_out;

    always_comb begin
        if (r_ins.mode == OP_DIV && r_b == '0) begin
            w_lat = DataW'(1);
        end else if (r_ins.mode <= 3'(OP_JUMP)) begin
            w_lat = DataW'(i_lat[r_ins.mode]);
        end else begin
            w_lat = DataW'(1);
        end
    end

    rabt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_ma),
        .i_den   (w_mb),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_cycle <= DataW'(1);
            r_out_v <= 1'b0;
        end else begin
            if (i_pop && r_out_v) r_out_v <= 1'b0;
            unique case (r_state)
                S_CLEAR: begin
                    r_rf[r_clr[IdxW-1:0]] <= '0;
                    r_clr <= r_clr + (IdxW+1)'(1);
                    if (r_clr == (IdxW+1)'(NUM_REGS - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (o_take) begin
                        r_ins   <= i_item;
                        r_ia    <= '0;
                        r_ib    <= '0;
                        r_id    <= '0;
                        r_step  <= '0;
                        r_state <= S_IDX;
                    end
                end
                S_IDX: begin
                    r_ia   <= reduce_chunk(r_ia, pick_chunk(r_ins.src_a_or_imm, r_step));
                    r_ib   <= reduce_chunk(r_ib, pick_chunk(r_ins.src_b_or_offset, r_step));
                    r_id   <= reduce_chunk(r_id, pick_chunk(r_ins.dest_or_compare, r_step));
                    r_step <= r_step + 2'd1;
                    if (r_step == 2'd3) r_state <= S_READ;
                end
                S_READ: begin
                    r_a     <= r_rf[r_ia];
                    r_b     <= r_rf[r_ib];
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    case (r_ins.mode)
                        OP_ADD:  begin r_val <= r_a + r_b; r_state <= S_DONE; end
                        OP_SUB:  begin r_val <= r_a - r_b; r_state <= S_DONE; end
                        OP_MUL:  begin r_val <= r_a * r_b; r_state <= S_DONE; end
                        OP_LOAD: begin r_val <= r_ins.src_a_or_imm; r_state <= S_DONE; end
                        OP_DIV: begin
                            if (r_b == '0) begin
                                r_val   <= r_a;
                                r_state <= S_DONE;
                            end else begin
                                r_state <= S_DIVW;
                            end
                        end
                        default: begin r_val <= '0; r_state <= S_DONE; end
                    endcase
                end
                S_DIVW: begin
                    if (w_div_done) begin
                        r_val   <= (r_a[DataW-1] != r_b[DataW-1]) ? (DataW'(0) - w_quot)
                                                                 : w_quot;
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    r_out.issue_cycle     <= r_cycle;
                    r_out.exec_cycle      <= r_cycle + w_lat;
                    r_out.writeback_cycle <= r_cycle + w_lat + DataW'(1);
                    r_cycle               <= r_cycle + w_lat + DataW'(2);
                    if (r_ins.mode == OP_JUMP) begin
                        r_out.wrote_register <= 1'b0;
                        r_out.written_value  <= '0;
                        r_out.pc_step <= (r_a == r_ins.dest_or_compare)
                            ? r_ins.src_b_or_offset : DataW'(1);
                    end else if (r_ins.mode <= 3'(OP_LOAD)) begin
                        r_out.wrote_register <= 1'b1;
                        r_out.written_value  <= r_val;
                        r_out.pc_step        <= DataW'(1);
                        r_rf[r_id]           <= r_val;
                    end else begin
                        r_out.wrote_register <= 1'b0;
                        r_out.written_value  <= '0;
                        r_out.pc_step        <= DataW'(1);
                    end
                    r_out_v <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== rtl/register_alu_with_branch_timing.sv =====
`default_nettype none
// Path: an accepted push passes through the front queue, then the back-end states
// S_IDX, S_READ, S_EXEC and S_DONE before the result is shown; a divide by a nonzero
// register also waits in S_DIVW for the divider, which gives one quotient bit per cycle.
// Issue: one transaction at a time in the back end, taken the cycle after the previous
// result is popped. Reset: synchronous, active low; afterwards a clearing pass over all
// NUM_REGS registers zeroes the register file before the first transaction executes.
module register_alu_with_branch_timing
    import rabt_pkg::*;
#(
    parameter int unsigned NUM_REGS = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire t_in_item           i_item,
    output logic                    empty,
    input  wire logic               pop,
    output t_out_item               o_item,
    input  wire logic               i_cfg_we,
    input  wire logic [CfgIdxW-1:0] i_cfg_idx,
    input  wire logic [LatW-1:0]    i_cfg_data
);
    // Latency configuration registers, reset to a value of one each.
    logic [LatW-1:0] r_lat [NumCfg];
    logic            w_valid, w_take;
    t_in_item        w_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NumCfg; i++) r_lat[i] <= LatW'(1);
        end else if (i_cfg_we) begin
            // Writes to an index beyond the register list are dropped.
            case (i_cfg_idx) inside
                CFG_LAT_ADD, CFG_LAT_SUB, CFG_LAT_MUL,
                CFG_LAT_DIV, CFG_LAT_LOAD, CFG_LAT_JUMP: r_lat[i_cfg_idx] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // The front queue accepts transactions while the back end works.
    rabt_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (full),
        .i_item  (i_item),
        .o_valid (w_valid),
        .i_take  (w_take),
        .o_item  (w_item)
    );

    // The back end reduces the register indexes in four S_IDX steps of one byte each, reads the
    // register file, executes one transaction and holds its result until popped.
    rabt_back #(.NUM_REGS(NUM_REGS)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_valid),
        .o_take  (w_take),
        .i_item  (w_item),
        .i_lat   (r_lat),
        .o_empty (empty),
        .i_pop   (pop),
        .o_item  (o_item)
    );
endmodule
`default_nettype wire

// ===== rtl/rabt_checker.sv =====
`default_nettype none
`include "register_alu_with_branch_timing_defines.svh"
module rabt_checker
    import rabt_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      empty,
    input wire logic      pop,
    input wire t_out_item o_item
);
    `RABT_ASSERT_IMP(a_wb_follows_exec, i_clk, i_rst_n, !empty,
        o_item.writeback_cycle == o_item.exec_cycle + 32'd1, "writeback stamp not exec plus one")
    `RABT_ASSERT_IMP(a_jump_no_write, i_clk, i_rst_n, !empty && !o_item.wrote_register,
        o_item.written_value == 32'sd0, "value without write")
    `RABT_ASSERT_NXT(a_hold, i_clk, i_rst_n, !empty && !pop,
        !empty && $stable(o_item), "result changed while waiting")
endmodule
bind register_alu_with_branch_timing rabt_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .empty(empty), .pop(pop), .o_item(o_item)
);
`default_nettype wire
